// ===== src/flow_priority_queue_top_defines.svh =====
// Assertion macros for the flow priority queue.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef FLOW_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define FLOW_PRIORITY_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define FPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FPQ_ASSERT(label, clk, rst_n, prop, msg)
`define FPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/fpq_pkg.sv =====
// Shared types and constants of the flow priority queue.
// No dependencies; used by the interfaces, the slot store and the top level.
package fpq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned ID_W   = 8;
    localparam int unsigned TIME_W = 16;
    localparam int unsigned PRIO_W = 8;
    localparam int unsigned AGE_W  = 8;
    localparam int unsigned OCC_W  = 5;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned KEY_W  = PRIO_W + 2 * TIME_W;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] send;
        logic [ID_W-1:0]   id;
    } t_flow;

    typedef struct packed {
        logic we_flow;
        logic we_age;
    } t_mem_we;

endpackage

// ===== src/fpq_intf.sv =====
// Request and response channel interfaces of the flow priority queue.
// Depends on fpq_pkg for the field widths.
interface fpq_req_if
    import fpq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [ID_W-1:0]   flow_id;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] send_time;
    logic [PRIO_W-1:0] prio;

    modport source (output valid, func, flow_id, arrival_time, send_time, prio,
                    input ready);
    modport sink   (input valid, func, flow_id, arrival_time, send_time, prio,
                    output ready);
endinterface

interface fpq_rsp_if
    import fpq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_id;
    logic [TIME_W-1:0] out_arrival;
    logic [TIME_W-1:0] out_send_time;
    logic [PRIO_W-1:0] out_prio;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, status, out_id, out_arrival, out_send_time,
                    out_prio, occupancy, input ready);
    modport sink   (input valid, status, out_id, out_arrival, out_send_time,
                    out_prio, occupancy, output ready);
endinterface

// ===== src/fpq_store.sv =====
// Slot store of the flow priority queue: flow record and insertion rank per slot.
// Depends on fpq_pkg; one write address and one read address per cycle, with registered read data.
module fpq_store
    import fpq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int unsigned IDX_W       = $clog2(QUEUE_DEPTH)
) (
    input  logic             i_clk,
    input  t_mem_we          i_we,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_flow            i_wr_flow,
    input  logic [AGE_W-1:0] i_wr_age,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_flow            o_rd_flow,
    output logic [AGE_W-1:0] o_rd_age
);

    t_flow            r_flow_mem [QUEUE_DEPTH];
    logic [AGE_W-1:0] r_age_mem  [QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.we_flow) begin
            r_flow_mem[i_wr_addr] <= i_wr_flow;
        end
        if (i_we.we_age) begin
            r_age_mem[i_wr_addr] <= i_wr_age;
        end
        o_rd_flow <= r_flow_mem[i_rd_addr];
        o_rd_age  <= r_age_mem[i_rd_addr];
    end

endmodule

// ===== src/flow_priority_queue_top.sv =====
// Flow priority queue: holds up to QUEUE_DEPTH waiting flows and serves one request
// at a time. An enqueue takes the lowest free slot and returns after the valid bits
// up to that slot have been walked; a full queue or an empty dequeue answers without
// a walk. A dequeue walks every slot through one key comparator, removes the winner
// and then walks the slots again to close the gap in the insertion ranks. The single
// read port of the slot store sets both walks. The next request is taken while a
// finished response still waits in the output register.
module flow_priority_queue_top
    import fpq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    fpq_req_if.sink   i_req,
    fpq_rsp_if.source o_rsp
);

`include "flow_priority_queue_top_defines.svh"

    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ENQ   = 3'd1;
    localparam logic [2:0] S_DSCAN = 3'd2;
    localparam logic [2:0] S_DLAST = 3'd3;
    localparam logic [2:0] S_DREM  = 3'd4;
    localparam logic [2:0] S_AGE   = 3'd5;
    localparam logic [2:0] S_ALAST = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]             r_state, n_state;
    logic [QUEUE_DEPTH-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_cmp_en, n_cmp_en;
    logic                   r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx, n_rd_idx;
    logic                   r_have_best, n_have_best;
    t_flow                  r_best_flow, n_best_flow;
    logic [AGE_W-1:0]       r_best_age, n_best_age;
    logic [IDX_W-1:0]       r_best_idx, n_best_idx;
    logic                   r_func, n_func;
    t_flow                  r_in_flow, n_in_flow;
    logic [STAT_W-1:0]      r_status, n_status;
    logic                   r_ovld, n_ovld;
    logic [STAT_W-1:0]      r_o_status, n_o_status;
    t_flow                  r_o_flow, n_o_flow;
    logic [OCC_W-1:0]       r_o_occ, n_o_occ;

    t_mem_we          mem_we;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [AGE_W-1:0] mem_wr_age;
    t_flow            rd_flow;
    logic [AGE_W-1:0] rd_age;
    logic [KEY_W-1:0] rd_key, best_key;
    logic             cmp_better;
    logic             req_fire;

    fpq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_flow (r_in_flow),
        .i_wr_age  (mem_wr_age),
        .i_rd_addr (r_idx),
        .o_rd_flow (rd_flow),
        .o_rd_age  (rd_age)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    // Comparator of the dequeue walk: priority, then arrival, then send time, then insertion rank; lower wins.
    assign rd_key     = {rd_flow.prio, rd_flow.arrival, rd_flow.send};
    assign best_key   = {r_best_flow.prio, r_best_flow.arrival, r_best_flow.send};
    assign cmp_better = !r_have_best || (rd_key < best_key) ||
                        ((rd_key == best_key) && (rd_age < r_best_age));

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_count     = r_count;
        n_idx       = r_idx;
        n_cmp_en    = 1'b0;
        n_rd_vld    = r_valid[r_idx];
        n_rd_idx    = r_idx;
        n_have_best = r_have_best;
        n_best_flow = r_best_flow;
        n_best_age  = r_best_age;
        n_best_idx  = r_best_idx;
        n_func      = r_func;
        n_in_flow   = r_in_flow;
        n_status    = r_status;
        n_ovld      = r_ovld && !o_rsp.ready;
        n_o_status  = r_o_status;
        n_o_flow    = r_o_flow;
        n_o_occ     = r_o_occ;
        mem_we      = '0;
        mem_wr_addr = r_idx;
        mem_wr_age  = AGE_W'(r_count);

        // Second stage of the slot walks, one read behind the address.
        if ((r_state == S_DSCAN || r_state == S_DLAST) && r_cmp_en && r_rd_vld &&
            cmp_better) begin
            n_have_best = 1'b1;
            n_best_flow = rd_flow;
            n_best_age  = rd_age;
            n_best_idx  = r_rd_idx;
        end
        if ((r_state == S_AGE || r_state == S_ALAST) && r_cmp_en && r_rd_vld &&
            (rd_age > r_best_age)) begin
            mem_we.we_age = 1'b1;
            mem_wr_addr   = r_rd_idx;
            mem_wr_age    = rd_age - AGE_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_func      = i_req.func;
                    n_in_flow   = '{prio: i_req.prio, arrival: i_req.arrival_time,
                                    send: i_req.send_time, id: i_req.flow_id};
                    n_idx       = '0;
                    n_have_best = 1'b0;
                    n_status    = STAT_OK;
                    if (i_req.func == FUNC_ENQ) begin
                        if (r_count == FULL_CNT) begin
                            n_status = STAT_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_ENQ;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_DSCAN;
                        end
                    end
                end
            end
            S_ENQ: begin
                if (!r_valid[r_idx]) begin
                    mem_we.we_flow = 1'b1;
                    mem_we.we_age  = 1'b1;
                    n_valid[r_idx] = 1'b1;
                    n_count        = r_count + CNT_W'(1);
                    n_state        = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DSCAN: begin
                n_cmp_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DLAST;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DLAST: begin
                n_state = S_DREM;
            end
            S_DREM: begin
                n_valid[r_best_idx] = 1'b0;
                n_count             = r_count - CNT_W'(1);
                n_idx               = '0;
                n_state             = S_AGE;
            end
            S_AGE: begin
                n_cmp_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_ALAST;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_ALAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovld || o_rsp.ready) begin
                    n_ovld     = 1'b1;
                    n_o_status = r_status;
                    n_o_flow   = (r_func == FUNC_DEQ && r_status == STAT_OK) ?
                                 r_best_flow : '0;
                    n_o_occ    = OCC_W'(r_count);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_cmp_en    <= 1'b0;
            r_have_best <= 1'b0;
            r_ovld      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_cmp_en    <= n_cmp_en;
            r_have_best <= n_have_best;
            r_ovld      <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_rd_vld    <= n_rd_vld;
        r_rd_idx    <= n_rd_idx;
        r_best_flow <= n_best_flow;
        r_best_age  <= n_best_age;
        r_best_idx  <= n_best_idx;
        r_func      <= n_func;
        r_in_flow   <= n_in_flow;
        r_status    <= n_status;
        r_o_status  <= n_o_status;
        r_o_flow    <= n_o_flow;
        r_o_occ     <= n_o_occ;
    end

    assign o_rsp.valid         = r_ovld;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.out_id        = r_o_flow.id;
    assign o_rsp.out_arrival   = r_o_flow.arrival;
    assign o_rsp.out_send_time = r_o_flow.send;
    assign o_rsp.out_prio      = r_o_flow.prio;
    assign o_rsp.occupancy     = r_o_occ;

    // The fill count must always agree with the valid bits.
    `FPQ_ASSERT(a_count_matches_valid, i_clk, i_rst_n, $countones(r_valid) == r_count, "count and valid bits disagree")
    `FPQ_ASSERT_IMPL(a_enq_has_room, i_clk, i_rst_n, r_state == S_ENQ, r_count < FULL_CNT, "enqueue walk with a full queue")
    `FPQ_ASSERT_IMPL(a_deq_has_flow, i_clk, i_rst_n, r_state == S_DSCAN, r_count != '0, "dequeue walk with an empty queue")
    `FPQ_ASSERT_IMPL(a_removal_has_winner, i_clk, i_rst_n, r_state == S_DREM, r_have_best && r_valid[r_best_idx], "removal without a valid winner")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench of flow_priority_queue_top: enqueues and dequeues flows over the request
// channel and checks every response against a model of the slot store kept here or a fixed answer.
// Depends on fpq_pkg and the fpq_req_if / fpq_rsp_if channel interfaces.
module testbench
    import fpq_pkg::*;
;
    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int RANDOM_REQUESTS = 400;

    typedef struct packed {
        logic  func;
        t_flow flow;
    } t_request;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_flow             flow;
        logic [OCC_W-1:0]  occ;
    } t_answer;

    typedef struct packed {
        t_request req;
        logic     fixed;
        t_answer  ans;
    } t_row;

    logic clk;
    logic rst_n;
    int   error_count = 0;
    int   max_idle = 4;

    fpq_req_if req_ch ();
    fpq_rsp_if rsp_ch ();

    flow_priority_queue_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Model of the slot store: flows, valid bits and insertion ranks.
    t_flow            slot_flow [DEPTH];
    logic             slot_used [DEPTH];
    logic [AGE_W-1:0] slot_rank [DEPTH];
    int               flows_waiting;

    t_answer awaited_answers [$];
    t_row    directed_rows [$];

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic t_answer serve_request(t_request r);
        t_answer          a;
        int               slot;
        int               best;
        logic [KEY_W-1:0] key_i;
        logic [KEY_W-1:0] key_b;
        logic [AGE_W-1:0] gone_rank;
        a = '0;
        slot = -1;
        best = -1;
        if (r.func == FUNC_ENQ) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (slot < 0 && !slot_used[i]) slot = i;
            end
            if (slot < 0) begin
                a.status = STAT_FULL;
            end else begin
                slot_flow[slot] = r.flow;
                slot_used[slot] = 1'b1;
                slot_rank[slot] = flows_waiting[AGE_W-1:0];
                flows_waiting++;
                a.status = STAT_OK;
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                if (slot_used[i]) begin
                    if (best < 0) begin
                        best = i;
                    end else begin
                        key_i = {slot_flow[i].prio, slot_flow[i].arrival, slot_flow[i].send};
                        key_b = {slot_flow[best].prio, slot_flow[best].arrival,
                                 slot_flow[best].send};
                        if (key_i < key_b || (key_i == key_b && slot_rank[i] < slot_rank[best]))
                            best = i;
                    end
                end
            end
            if (best < 0) begin
                a.status = STAT_EMPTY;
            end else begin
                a.status = STAT_OK;
                a.flow = slot_flow[best];
                gone_rank = slot_rank[best];
                slot_used[best] = 1'b0;
                // Close the gap in the ranks left by the removed flow.
                for (int i = 0; i < DEPTH; i++) begin
                    if (slot_used[i] && slot_rank[i] > gone_rank) slot_rank[i]--;
                end
                flows_waiting--;
            end
        end
        a.occ = flows_waiting[OCC_W-1:0];
        return a;
    endfunction

    task automatic add_row(input logic func, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] snd,
                           input logic [PRIO_W-1:0] prio, input logic fixed,
                           input logic [STAT_W-1:0] st, input logic [ID_W-1:0] o_id,
                           input logic [TIME_W-1:0] o_arr, input logic [TIME_W-1:0] o_snd,
                           input logic [PRIO_W-1:0] o_prio, input logic [OCC_W-1:0] occ);
        t_row row;
        row.req.func = func;
        row.req.flow = '{prio: prio, arrival: arr, send: snd, id: id};
        row.fixed = fixed;
        row.ans.status = st;
        row.ans.flow = '{prio: o_prio, arrival: o_arr, send: o_snd, id: o_id};
        row.ans.occ = occ;
        directed_rows.push_back(row);
    endtask

    // Presents one request and waits for it to be taken; the expectation is queued
    // at the accepting edge, before the response can possibly appear.
    task automatic issue(input t_request r, input logic fixed, input t_answer fixed_ans);
        int      gap;
        t_answer predicted;
        gap = $urandom_range(0, max_idle);
        @(negedge clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= r.func;
        req_ch.flow_id      <= r.flow.id;
        req_ch.arrival_time <= r.flow.arrival;
        req_ch.send_time    <= r.flow.send;
        req_ch.prio         <= r.flow.prio;
        do @(posedge clk); while (!req_ch.ready);
        predicted = serve_request(r);
        awaited_answers.push_back(fixed ? fixed_ans : predicted);
    endtask

    // The last request has been taken, so the request line is dropped before waiting.
    task automatic drain_answers();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge clk);
    endtask

    function automatic t_request random_request(int enq_pct);
        t_request r;
        r.func = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
        r.flow.id = ID_W'($urandom_range(0, 255));
        // Half of the flows come from a narrow range so that keys tie often.
        if ($urandom_range(0, 1)) begin
            r.flow.prio    = PRIO_W'($urandom_range(0, 255));
            r.flow.arrival = TIME_W'($urandom_range(0, 65535));
            r.flow.send    = TIME_W'($urandom_range(0, 65535));
        end else begin
            r.flow.prio    = PRIO_W'($urandom_range(0, 2));
            r.flow.arrival = TIME_W'($urandom_range(0, 2));
            r.flow.send    = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        t_answer want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_answers.size() == 0) begin
                $error("response arrived with no request outstanding");
                error_count++;
            end else begin
                want = awaited_answers.pop_front();
                check_field("status", want.status, rsp_ch.status);
                check_field("out_id", want.flow.id, rsp_ch.out_id);
                check_field("out_arrival", want.flow.arrival, rsp_ch.out_arrival);
                check_field("out_send_time", want.flow.send, rsp_ch.out_send_time);
                check_field("out_prio", want.flow.prio, rsp_ch.out_prio);
                check_field("occupancy", want.occ, rsp_ch.occupancy);
            end
        end
    end

    // Response side: holds ready low for a random stall before each response.
    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            stall = $urandom_range(0, max_idle);
            @(negedge clk);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int       sent;
        int       phase_len;
        int       enq_pct;
        t_request r;
        t_row     row;

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.func         <= FUNC_ENQ;
        req_ch.flow_id      <= '0;
        req_ch.arrival_time <= '0;
        req_ch.send_time    <= '0;
        req_ch.prio         <= '0;
        for (int i = 0; i < DEPTH; i++) begin
            slot_flow[i] = '0;
            slot_used[i] = 1'b0;
            slot_rank[i] = '0;
        end
        flows_waiting = 0;

        // Empty dequeue, the field extremes, rank and key ties, a full queue, then five dequeues.
        add_row(FUNC_DEQ, 8'h00, 16'h0000, 16'h0000, 8'h00,
                1'b1, STAT_EMPTY, 8'h00, 16'h0000, 16'h0000, 8'h00, 5'd0);
        add_row(FUNC_ENQ, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                1'b1, STAT_OK, 8'h00, 16'h0000, 16'h0000, 8'h00, 5'd1);
        add_row(FUNC_DEQ, 8'h00, 16'h0000, 16'h0000, 8'h00,
                1'b1, STAT_OK, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 5'd0);
        add_row(FUNC_ENQ, 8'h00, 16'h0000, 16'h0000, 8'h00,
                1'b1, STAT_OK, 8'h00, 16'h0000, 16'h0000, 8'h00, 5'd1);
        add_row(FUNC_ENQ, 8'h01, 16'd100, 16'd50, 8'h10, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h02, 16'd100, 16'd50, 8'h10, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h03, 16'd100, 16'd50, 8'h10, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h04, 16'd100, 16'd40, 8'h10, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h05, 16'd90,  16'd60, 8'h10, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h06, 16'd500, 16'd500, 8'h0F, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h08, 16'hAAAA, 16'h5555, 8'hAA, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h09, 16'h5555, 16'hAAAA, 8'h55, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h0A, 16'h0000, 16'hFFFF, 8'h00, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h0B, 16'hFFFF, 16'h0000, 8'h00, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h0C, 16'h0001, 16'h0001, 8'h01, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h0D, 16'h8000, 16'h0001, 8'h80, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h0E, 16'h0001, 16'h8000, 8'h01, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h0F, 16'h0007, 16'h0007, 8'hFE, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h10, 16'h00FF, 16'hFF00, 8'h0F, 1'b0, '0, '0, '0, '0, '0, '0);
        add_row(FUNC_ENQ, 8'h11, 16'h1234, 16'h4321, 8'h33,
                1'b1, STAT_FULL, 8'h00, 16'h0000, 16'h0000, 8'h00, 5'd16);
        repeat (5)
            add_row(FUNC_DEQ, 8'h00, 16'h0000, 16'h0000, 8'h00,
                    1'b0, '0, '0, '0, '0, '0, '0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            issue(row.req, row.fixed, row.ans);
        end
        // Hold the request side until every response is back.
        drain_answers();

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            phase_len = $urandom_range(20, 60);
            if (phase_len > RANDOM_REQUESTS - sent) phase_len = RANDOM_REQUESTS - sent;
            case ($urandom_range(0, 4))
                0: enq_pct = 10;
                1: enq_pct = 25;
                2: enq_pct = 50;
                3: enq_pct = 75;
                default: enq_pct = 90;
            endcase
            max_idle = ($urandom_range(0, 3) == 0) ? 0 : 4;
            repeat (phase_len) begin
                r = random_request(enq_pct);
                issue(r, 1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 2) == 0) drain_answers();
        end
        max_idle = 4;

        drain_answers();
        repeat (64) @(posedge clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== flow_priority_queue_top.f =====
+incdir+src
src/fpq_pkg.sv
src/fpq_intf.sv
src/fpq_store.sv
src/flow_priority_queue_top.sv
tb/testbench.sv
